// ===== src/sfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int MAX_BYTES_DEF = 1024;
  localparam int SEG_BYTES     = 6;

  // field widths
  localparam int REQ_W  = 3;
  localparam int ID_W   = 11;
  localparam int CNT_W  = 11;
  localparam int W16    = 16;
  localparam int DATA_W = 64;
  localparam int ST_W   = 3;

  // byte position within a transfer: below 2047 + 6
  localparam int POS_W  = 12;
  // segment count: ceil(2047 / 6) = 342
  localparam int SEGN_W = 9;
  localparam int FC_W   = 3;
  localparam logic [FC_W-1:0] FC_LAST = FC_W'(SEG_BYTES);

  // ceil(n/6) = ((n + 5) * 2731) >> 14, exact for n + 5 below 4096
  localparam int RECIP6_W  = 12;
  localparam logic [RECIP6_W-1:0] RECIP6 = 12'd2731;
  localparam int RECIP6_SH = 14;

  localparam logic [W16-1:0] ACK_PATTERN = 16'hABBA;
  localparam logic [W16-1:0] TIMEOUT_RST = 16'd100;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // config port: one 32-bit register, index in paddr[2]
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic RK_FRAME = 1'b0;
  localparam logic RK_DONE  = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 3'd0,
    REQ_START   = 3'd1,
    REQ_ACK     = 3'd2,
    REQ_TICK    = 3'd3,
    REQ_REFUSE  = 3'd4,
    REQ_RXFAULT = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_START,
    OP_ACK,
    OP_TICK,
    OP_ABORT
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_REFUSED = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_RXFAULT = 3'd3,
    ST_BADACK  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR,
    PH_SEG
  } phase_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_FETCH,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [7:0]       data_byte;
    logic [ID_W-1:0]  target_id;
    logic [W16-1:0]   command;
    logic [CNT_W-1:0] byte_count;
    logic [W16-1:0]   ack_id;
    logic [W16-1:0]   ack_word;
  } sfs_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] frame_data;
    logic [ST_W-1:0]   status;
  } sfs_out_t;

  typedef struct packed {
    op_t              op;
    status_t          abort_st;
    logic [7:0]       data_byte;
    logic [ID_W-1:0]  target_id;
    logic [W16-1:0]   command;
    logic [CNT_W-1:0] byte_count;
    logic [W16-1:0]   ack_id;
    logic             ack_word_ok;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

`default_nettype wire

// ===== src/sfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/sfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sfs_pkg::sfs_in_t in_data,
  output sfs_pkg::q_head_t      q_head,
  input  wire logic             q_pop
);

  sfs_pkg::q_entry_t q_r [sfs_pkg::QDEPTH];
  logic [sfs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sfs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sfs_pkg::QPTR_W:0]   count_r, count_nxt;

  sfs_pkg::q_entry_t ent_c;
  logic              keep_c;
  logic              push;

  // decode the request; unknown codes are taken and dropped here
  always_comb begin
    keep_c            = 1'b1;
    ent_c.op          = sfs_pkg::OP_LOAD;
    ent_c.abort_st    = sfs_pkg::ST_OK;
    ent_c.data_byte   = in_data.data_byte;
    ent_c.target_id   = in_data.target_id;
    ent_c.command     = in_data.command;
    ent_c.byte_count  = in_data.byte_count;
    ent_c.ack_id      = in_data.ack_id;
    ent_c.ack_word_ok = (in_data.ack_word == sfs_pkg::ACK_PATTERN);
    unique case (in_data.req_type)
      sfs_pkg::REQ_LOAD:  ent_c.op = sfs_pkg::OP_LOAD;
      sfs_pkg::REQ_START: ent_c.op = sfs_pkg::OP_START;
      sfs_pkg::REQ_ACK:   ent_c.op = sfs_pkg::OP_ACK;
      sfs_pkg::REQ_TICK:  ent_c.op = sfs_pkg::OP_TICK;
      sfs_pkg::REQ_REFUSE: begin
        ent_c.op       = sfs_pkg::OP_ABORT;
        ent_c.abort_st = sfs_pkg::ST_REFUSED;
      end
      sfs_pkg::REQ_RXFAULT: begin
        ent_c.op       = sfs_pkg::OP_ABORT;
        ent_c.abort_st = sfs_pkg::ST_RXFAULT;
      end
      default: keep_c = 1'b0;
    endcase
  end

  assign in_stall = (count_r == (sfs_pkg::QPTR_W + 1)'(sfs_pkg::QDEPTH));
  assign push     = in_valid && !in_stall && keep_c;

  assign q_head.valid = (count_r != '0);
  assign q_head.entry = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent_c;
    end
  end

endmodule

`default_nettype wire

// ===== src/sfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfs_back #(
  parameter int MAX_BYTES = sfs_pkg::MAX_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfs_pkg::q_head_t            q_head,
  output logic                             q_pop,
  input  wire logic [sfs_pkg::W16-1:0]     timeout,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output sfs_pkg::sfs_out_t                out_data
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int LW = $clog2(MAX_BYTES + 1);
  localparam int PROD_W = 2 * sfs_pkg::RECIP6_W;

  sfs_pkg::bk_state_t state_r, state_nxt;
  sfs_pkg::phase_t    phase_r, phase_nxt;

  logic [LW-1:0]                 load_pos_r, load_pos_nxt;
  logic [sfs_pkg::CNT_W-1:0]     xfer_r, xfer_nxt;
  logic [sfs_pkg::SEGN_W-1:0]    seg_total_r, seg_total_nxt;
  logic [sfs_pkg::SEGN_W-1:0]    seg_idx_r, seg_idx_nxt;
  logic [sfs_pkg::POS_W-1:0]     seg_base_r, seg_base_nxt;
  logic [sfs_pkg::W16-1:0]       wait_r, wait_nxt;
  logic [sfs_pkg::ID_W-1:0]      target_r, target_nxt;
  logic [sfs_pkg::FC_W-1:0]      fc_r, fc_nxt;
  logic                          byte_ok_r;
  logic [8*sfs_pkg::SEG_BYTES-1:0] seg_bytes_r, seg_bytes_nxt;
  logic                          out_valid_r, out_valid_nxt;
  sfs_pkg::sfs_out_t             out_word_r, out_word_nxt;

  sfs_pkg::q_entry_t e;
  logic              slot_ok;
  logic              busy;
  logic              start_fetch;
  logic              out_load;

  logic [sfs_pkg::CNT_W-1:0]    n_sat;
  logic [sfs_pkg::RECIP6_W-1:0] n_plus;
  logic [PROD_W-1:0]            n_prod;
  logic [sfs_pkg::SEGN_W-1:0]   total_c;
  logic [sfs_pkg::SEGN_W-1:0]   idx_inc;
  logic [sfs_pkg::W16-1:0]      wait_sat;

  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [7:0]                   ram_rdata;
  logic [sfs_pkg::POS_W-1:0]    rd_pos;
  logic                         byte_ok_nxt;
  logic [sfs_pkg::FC_W-1:0]     slot;

  assign e       = q_head.entry;
  assign busy    = (phase_r != sfs_pkg::PH_IDLE);
  assign slot_ok = !out_valid_r || !out_stall;
  assign q_pop   = (state_r == sfs_pkg::BK_RUN) && q_head.valid && slot_ok;

  // start arithmetic: saturate and count segments
  assign n_sat  = (32'(e.byte_count) > 32'(MAX_BYTES)) ? sfs_pkg::CNT_W'(MAX_BYTES)
                                                       : e.byte_count;
  assign n_plus = sfs_pkg::RECIP6_W'(n_sat) + sfs_pkg::RECIP6_W'(sfs_pkg::SEG_BYTES - 1);
  assign n_prod = n_plus * sfs_pkg::RECIP6;
  assign total_c = n_prod[sfs_pkg::RECIP6_SH +: sfs_pkg::SEGN_W];

  assign idx_inc  = seg_idx_r + 1'b1;
  assign wait_sat = (wait_r != '1) ? wait_r + 1'b1 : wait_r;

  // byte fetch through the single read port
  assign rd_pos      = seg_base_r + sfs_pkg::POS_W'(fc_r);
  assign ram_re      = (state_r == sfs_pkg::BK_FETCH) && (fc_r != sfs_pkg::FC_LAST);
  assign ram_raddr   = AW'(rd_pos);
  assign byte_ok_nxt = (rd_pos < sfs_pkg::POS_W'(xfer_r));
  assign slot        = fc_r - 1'b1;

  sfs_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(load_pos_r)),
    .wdata (e.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfs_pkg::BK_RUN:   if (start_fetch) state_nxt = sfs_pkg::BK_FETCH;
      sfs_pkg::BK_FETCH: if (fc_r == sfs_pkg::FC_LAST) state_nxt = sfs_pkg::BK_EMIT;
      sfs_pkg::BK_EMIT:  if (slot_ok) state_nxt = sfs_pkg::BK_RUN;
      default:           state_nxt = sfs_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    load_pos_nxt  = load_pos_r;
    xfer_nxt      = xfer_r;
    seg_total_nxt = seg_total_r;
    seg_idx_nxt   = seg_idx_r;
    seg_base_nxt  = seg_base_r;
    wait_nxt      = wait_r;
    target_nxt    = target_r;
    fc_nxt        = fc_r;
    seg_bytes_nxt = seg_bytes_r;
    start_fetch   = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    out_word_nxt  = out_word_r;

    unique case (state_r)
      sfs_pkg::BK_RUN: begin
        if (q_pop) begin
          unique case (e.op)
            sfs_pkg::OP_LOAD: begin
              if (!busy && (32'(load_pos_r) < 32'(MAX_BYTES))) begin
                ram_we       = 1'b1;
                load_pos_nxt = load_pos_r + 1'b1;
              end
            end
            sfs_pkg::OP_START: begin
              if (!busy) begin
                xfer_nxt                = n_sat;
                seg_total_nxt           = total_c;
                seg_idx_nxt             = '0;
                seg_base_nxt            = '0;
                target_nxt              = e.target_id;
                load_pos_nxt            = '0;
                phase_nxt               = sfs_pkg::PH_HDR;
                wait_nxt                = '0;
                out_load                = 1'b1;
                out_word_nxt.result_kind = sfs_pkg::RK_FRAME;
                out_word_nxt.frame_id   = e.target_id;
                out_word_nxt.frame_data = {16'h0, sfs_pkg::W16'(total_c), e.command, 16'h0};
                out_word_nxt.status     = sfs_pkg::ST_OK;
              end
            end
            sfs_pkg::OP_ACK: begin
              out_word_nxt.result_kind = sfs_pkg::RK_DONE;
              out_word_nxt.frame_id   = target_r;
              out_word_nxt.frame_data = '0;
              out_word_nxt.status     = sfs_pkg::ST_OK;
              if (phase_r == sfs_pkg::PH_HDR) begin
                if (e.ack_id != '0 || !e.ack_word_ok) begin
                  out_load            = 1'b1;
                  out_word_nxt.status = sfs_pkg::ST_BADACK;
                end else if (seg_total_r == '0) begin
                  out_load = 1'b1;
                end else begin
                  phase_nxt    = sfs_pkg::PH_SEG;
                  seg_idx_nxt  = '0;
                  seg_base_nxt = '0;
                  start_fetch  = 1'b1;
                end
              end else if (phase_r == sfs_pkg::PH_SEG) begin
                if (e.ack_id != sfs_pkg::W16'(idx_inc) || !e.ack_word_ok) begin
                  out_load            = 1'b1;
                  out_word_nxt.status = sfs_pkg::ST_BADACK;
                end else if (idx_inc >= seg_total_r) begin
                  out_load = 1'b1;
                end else begin
                  seg_idx_nxt  = idx_inc;
                  seg_base_nxt = seg_base_r + sfs_pkg::POS_W'(sfs_pkg::SEG_BYTES);
                  start_fetch  = 1'b1;
                end
              end
              if (start_fetch) begin
                wait_nxt = '0;
                fc_nxt   = '0;
              end
            end
            sfs_pkg::OP_TICK: begin
              if (busy) begin
                wait_nxt = wait_sat;
                if (wait_sat >= timeout) begin
                  out_load                 = 1'b1;
                  out_word_nxt.result_kind = sfs_pkg::RK_DONE;
                  out_word_nxt.frame_id    = target_r;
                  out_word_nxt.frame_data  = '0;
                  out_word_nxt.status      = sfs_pkg::ST_TIMEOUT;
                end
              end
            end
            sfs_pkg::OP_ABORT: begin
              if (busy) begin
                out_load                 = 1'b1;
                out_word_nxt.result_kind = sfs_pkg::RK_DONE;
                out_word_nxt.frame_id    = target_r;
                out_word_nxt.frame_data  = '0;
                out_word_nxt.status      = e.abort_st;
              end
            end
            default: ;
          endcase
          // every finish drops back to idle
          if (out_load && out_word_nxt.result_kind == sfs_pkg::RK_DONE) begin
            phase_nxt = sfs_pkg::PH_IDLE;
            wait_nxt  = '0;
          end
        end
      end
      sfs_pkg::BK_FETCH: begin
        // read data is registered in the RAM, so it lags its address
        if (fc_r != '0) begin
          seg_bytes_nxt[slot*8 +: 8] = byte_ok_r ? ram_rdata : 8'h0;
        end
        if (fc_r != sfs_pkg::FC_LAST) begin
          fc_nxt = fc_r + 1'b1;
        end
      end
      sfs_pkg::BK_EMIT: begin
        if (slot_ok) begin
          out_load                 = 1'b1;
          out_word_nxt.result_kind = sfs_pkg::RK_FRAME;
          out_word_nxt.frame_id    = target_r;
          out_word_nxt.frame_data  = {seg_bytes_r, sfs_pkg::W16'(seg_idx_r) + 16'd1};
          out_word_nxt.status      = sfs_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfs_pkg::BK_RUN;
      phase_r     <= sfs_pkg::PH_IDLE;
      load_pos_r  <= '0;
      xfer_r      <= '0;
      seg_total_r <= '0;
      seg_idx_r   <= '0;
      seg_base_r  <= '0;
      wait_r      <= '0;
      target_r    <= '0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      load_pos_r  <= load_pos_nxt;
      xfer_r      <= xfer_nxt;
      seg_total_r <= seg_total_nxt;
      seg_idx_r   <= seg_idx_nxt;
      seg_base_r  <= seg_base_nxt;
      wait_r      <= wait_nxt;
      target_r    <= target_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_ok_r   <= byte_ok_nxt;
    seg_bytes_r <= seg_bytes_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfs_pkg::PH_IDLE) |-> (wait_r == '0))
    else $error("wait count not clear while idle");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfs_pkg::PH_SEG) |-> (seg_idx_r < seg_total_r))
    else $error("segment index past segment total");

  a_fetch_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sfs_pkg::BK_RUN) |-> (phase_r == sfs_pkg::PH_SEG))
    else $error("segment fetch outside segment phase");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.result_kind == sfs_pkg::RK_DONE)
      |-> (out_word_r.frame_data == '0))
    else $error("finish word carries frame data");

  a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.result_kind == sfs_pkg::RK_FRAME)
      |-> (out_word_r.status == sfs_pkg::ST_OK))
    else $error("frame word carries a status");

endmodule

`default_nettype wire

// ===== src/segmented_frame_sender_acked.sv =====
// Acknowledged segmented frame sender. Load payload bytes one word at a time, then a
// start word emits a header frame (command, segment count); each matching ack then
// emits the next 6-byte segment frame, and a bad ack, tick timeout, transmit refusal
// or receive fault ends the transfer with a status word. Input words enter a 4-deep
// queue, so the input side keeps accepting while a result waits on out_stall, until
// the queue fills. Loads, ticks, starts, aborts and acks that finish are handled at
// dispatch in the back end; an ack that releases a segment passes dispatch, six byte
// reads plus one capture through the single read port of the byte-wide payload RAM,
// and the emit. timeout_ticks sits at byte address 0 of the register port (reset 100).
`timescale 1ns / 1ps
`default_nettype none

module segmented_frame_sender_acked #(
  parameter int MAX_BYTES = sfs_pkg::MAX_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sfs_pkg::sfs_in_t              in_data,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output sfs_pkg::sfs_out_t                  out_data,

  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [sfs_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [sfs_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [sfs_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  logic [sfs_pkg::W16-1:0] timeout_r;
  logic                    cfg_wr;
  logic                    sel_timeout;

  sfs_pkg::q_head_t q_head;
  logic             q_pop;

  assign cfg_pready  = 1'b1;
  assign sel_timeout = (cfg_paddr[sfs_pkg::CFG_AW-1] == sfs_pkg::REG_TIMEOUT);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = sel_timeout ? sfs_pkg::CFG_DW'(timeout_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sfs_pkg::TIMEOUT_RST;
    end else if (cfg_wr && sel_timeout) begin
      timeout_r <= cfg_pwdata[sfs_pkg::W16-1:0];
    end
  end

  sfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  sfs_back #(
    .MAX_BYTES(MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .timeout   (timeout_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sfs_pkg::*;

  localparam int MAX_B = MAX_BYTES_DEF;
  localparam int CHK = 0;   // copy that follows accepted words
  localparam int PLAN = 1;  // copy that follows the stimulus as it is planned
  localparam int EFF_NONE = 0;
  localparam int EFF_STATE = 1;
  localparam int EFF_RESULT = 2;
  localparam logic [REQ_W-1:0] REQ_BOGUS_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BOGUS_HI = 3'd7;
  localparam logic [CFG_AW-1:0] TIMEOUT_ADDR = CFG_AW'({REG_TIMEOUT, 2'b00});
  localparam int QUIET = 64;
  localparam int LONG_HOLD = 300;
  localparam int unsigned LIMIT = 1000000;
  localparam int NUM_SETTINGS = 6;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sfs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sfs_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  segmented_frame_sender_acked #(.MAX_BYTES(MAX_B)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // two copies of the sender state: one tracks accepted words, one the plan
  logic [7:0] pay_mem [2][MAX_B];
  int unsigned load_pos [2];
  int unsigned fill_mark [2];
  int unsigned xfer_len [2];
  int unsigned seg_total [2];
  int unsigned seg_idx [2];
  int unsigned wait_cnt [2];
  int unsigned tgt [2];
  int unsigned tmo [2];
  phase_t ph [2];

  sfs_in_t tx_backlog [$];
  sfs_out_t due_results [$];
  int unsigned planned_eff = 0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned dones_seen = 0;
  int unsigned held_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned hold_left = 0;
  int unsigned recv_calm = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 100)
      $display("tb: mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
  endtask

  function automatic void sender_reset(input int c);
    for (int i = 0; i < MAX_B; i++) pay_mem[c][i] = 8'h00;
    load_pos[c] = 0;
    fill_mark[c] = 0;
    xfer_len[c] = 0;
    seg_total[c] = 0;
    seg_idx[c] = 0;
    wait_cnt[c] = 0;
    tgt[c] = 0;
    tmo[c] = TIMEOUT_RST;
    ph[c] = PH_IDLE;
  endfunction

  function automatic sfs_out_t frame_out(input int c, input logic [63:0] d);
    sfs_out_t r;
    r.result_kind = RK_FRAME;
    r.frame_id = ID_W'(tgt[c]);
    r.frame_data = d;
    r.status = ST_OK;
    wait_cnt[c] = 0;
    return r;
  endfunction

  function automatic sfs_out_t done_out(input int c, input status_t st);
    sfs_out_t r;
    r.result_kind = RK_DONE;
    r.frame_id = ID_W'(tgt[c]);
    r.frame_data = '0;
    r.status = st;
    ph[c] = PH_IDLE;
    wait_cnt[c] = 0;
    return r;
  endfunction

  // segment number in bytes 0-1, six payload bytes after it, zero past the end
  function automatic sfs_out_t segment_out(input int c);
    logic [63:0] d;
    int unsigned pos;
    d = 64'(16'(seg_idx[c] + 1));
    for (int i = 0; i < SEG_BYTES; i++) begin
      pos = seg_idx[c] * SEG_BYTES + i;
      if (pos < xfer_len[c] && pos < MAX_B)
        d = d | (64'(pay_mem[c][pos]) << (16 + 8 * i));
    end
    return frame_out(c, d);
  endfunction

  function automatic int sender_step(input int c, input sfs_in_t w, output sfs_out_t r);
    logic busy;
    int unsigned n;
    r = '0;
    busy = (ph[c] != PH_IDLE);
    case (w.req_type)
      REQ_LOAD: begin
        if (busy || load_pos[c] >= MAX_B) return EFF_NONE;
        pay_mem[c][load_pos[c]] = w.data_byte;
        load_pos[c]++;
        if (load_pos[c] > fill_mark[c]) fill_mark[c] = load_pos[c];
        return EFF_STATE;
      end
      REQ_START: begin
        if (busy) return EFF_NONE;
        n = w.byte_count;
        if (n > MAX_B) n = MAX_B;
        xfer_len[c] = n;
        seg_total[c] = (n + SEG_BYTES - 1) / SEG_BYTES;
        seg_idx[c] = 0;
        tgt[c] = w.target_id;
        load_pos[c] = 0;
        ph[c] = PH_HDR;
        r = frame_out(c, (64'(w.command) << 16) | (64'(16'(seg_total[c])) << 32));
        return EFF_RESULT;
      end
      REQ_ACK: begin
        if (!busy) return EFF_NONE;
        if (ph[c] == PH_HDR) begin
          if (w.ack_id != 16'd0 || w.ack_word != ACK_PATTERN)
            r = done_out(c, ST_BADACK);
          else if (seg_total[c] == 0)
            r = done_out(c, ST_OK);
          else begin
            ph[c] = PH_SEG;
            seg_idx[c] = 0;
            r = segment_out(c);
          end
          return EFF_RESULT;
        end
        if (w.ack_id != 16'(seg_idx[c] + 1) || w.ack_word != ACK_PATTERN) begin
          r = done_out(c, ST_BADACK);
          return EFF_RESULT;
        end
        seg_idx[c]++;
        if (seg_idx[c] >= seg_total[c]) r = done_out(c, ST_OK);
        else r = segment_out(c);
        return EFF_RESULT;
      end
      REQ_TICK: begin
        if (!busy) return EFF_NONE;
        if (wait_cnt[c] < 16'hFFFF) wait_cnt[c]++;
        if (wait_cnt[c] >= tmo[c]) begin
          r = done_out(c, ST_TIMEOUT);
          return EFF_RESULT;
        end
        return EFF_STATE;
      end
      REQ_REFUSE: begin
        if (!busy) return EFF_NONE;
        r = done_out(c, ST_REFUSED);
        return EFF_RESULT;
      end
      REQ_RXFAULT: begin
        if (!busy) return EFF_NONE;
        r = done_out(c, ST_RXFAULT);
        return EFF_RESULT;
      end
      default: return EFF_NONE;
    endcase
  endfunction

  // ---------------- stimulus planning ----------------

  function automatic sfs_in_t rand_word(input logic [REQ_W-1:0] q);
    logic [95:0] bits;
    sfs_in_t w;
    bits = {$urandom, $urandom, $urandom};
    w = bits[$bits(sfs_in_t)-1:0];
    w.req_type = q;
    return w;
  endfunction

  function automatic void plan(input sfs_in_t w);
    sfs_out_t r;
    if (sender_step(PLAN, w, r) != EFF_NONE) planned_eff++;
    tx_backlog.push_back(w);
  endfunction

  function automatic sfs_in_t start_word(input logic [ID_W-1:0] id,
                                         input logic [W16-1:0] cmd,
                                         input logic [CNT_W-1:0] n);
    sfs_in_t w;
    w = rand_word(REQ_START);
    w.target_id = id;
    w.command = cmd;
    w.byte_count = n;
    return w;
  endfunction

  function automatic sfs_in_t good_ack();
    sfs_in_t w;
    w = rand_word(REQ_ACK);
    w.ack_id = (ph[PLAN] == PH_HDR) ? 16'd0 : 16'(seg_idx[PLAN] + 1);
    w.ack_word = ACK_PATTERN;
    return w;
  endfunction

  function automatic sfs_in_t load_word(input logic [7:0] b);
    sfs_in_t w;
    w = rand_word(REQ_LOAD);
    w.data_byte = b;
    return w;
  endfunction

  function automatic sfs_in_t noise_word();
    case ($urandom_range(0, 5))
      0: return rand_word(REQ_ACK);
      1: return rand_word(REQ_TICK);
      2: return rand_word(REQ_REFUSE);
      3: return rand_word(REQ_RXFAULT);
      4: return rand_word(REQ_BOGUS_LO);
      default: return rand_word(REQ_BOGUS_HI);
    endcase
  endfunction

  // mostly matching acks; the rest ticks, aborts, bad acks and ignored words
  function automatic sfs_in_t busy_word();
    sfs_in_t w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) return good_ack();
    if (r < 82) return rand_word(REQ_TICK);
    if (r < 85) begin
      w = good_ack();
      case ($urandom_range(0, 2))
        0: w.ack_id = w.ack_id ^ 16'($urandom_range(1, 65535));
        1: w.ack_word = w.ack_word ^ 16'($urandom_range(1, 65535));
        default: begin
          w.ack_id = 16'($urandom);
          w.ack_word = 16'($urandom);
        end
      endcase
      return w;
    end
    if (r < 87) return rand_word(REQ_REFUSE);
    if (r < 89) return rand_word(REQ_RXFAULT);
    if (r < 93) return rand_word(REQ_LOAD);
    if (r < 96) return rand_word(REQ_START);
    return ($urandom_range(0, 1) == 0) ? rand_word(REQ_BOGUS_LO) : rand_word(REQ_BOGUS_HI);
  endfunction

  // one transfer from loading to completion; only bytes already written are sent
  function automatic void plan_transfer();
    int unsigned nload;
    int unsigned n;
    int unsigned lim;
    int unsigned r;
    logic storm;
    nload = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 14);
    repeat (nload) plan(load_word(8'($urandom)));
    if ($urandom_range(0, 7) == 0) plan(noise_word());
    r = $urandom_range(0, 9);
    lim = (fill_mark[PLAN] < 40) ? fill_mark[PLAN] : 40;
    if (r < 6) n = load_pos[PLAN];
    else if (r < 9) n = $urandom_range(0, lim);
    else if (fill_mark[PLAN] == MAX_B && $urandom_range(0, 1) == 0)
      n = $urandom_range(MAX_B, 2047);
    else n = $urandom_range(0, fill_mark[PLAN]);
    plan(start_word(ID_W'($urandom), W16'($urandom), CNT_W'(n)));
    storm = ($urandom_range(0, 29) == 0) && (tmo[PLAN] <= 200);
    while (ph[PLAN] != PH_IDLE) begin
      if (storm) plan(rand_word(REQ_TICK));
      else plan(busy_word());
    end
  endfunction

  function automatic void plan_random(input int unsigned cnt);
    int unsigned base;
    base = planned_eff;
    while (planned_eff - base < cnt) plan_transfer();
  endfunction

  // edge values, every request kind and the idle and busy corner cases
  function automatic void plan_directed();
    logic [7:0] dir_bytes [7] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7E};
    sfs_in_t w;
    plan(rand_word(REQ_ACK));
    plan(rand_word(REQ_TICK));
    plan(rand_word(REQ_REFUSE));
    plan(rand_word(REQ_RXFAULT));
    plan(rand_word(REQ_BOGUS_LO));
    plan(rand_word(REQ_BOGUS_HI));
    foreach (dir_bytes[i]) plan(load_word(dir_bytes[i]));
    plan(start_word(11'h7FF, 16'hFFFF, 11'd7));
    plan(load_word(8'h33));
    plan(start_word(11'h155, 16'h1234, 11'd3));
    plan(good_ack());
    plan(good_ack());
    plan(good_ack());
    plan(start_word(11'h000, 16'h0000, 11'd0));
    plan(good_ack());
    plan(start_word(ID_W'($urandom), W16'($urandom), 11'd1));
    plan(rand_word(REQ_RXFAULT));
    plan(start_word(ID_W'($urandom), W16'($urandom), 11'd6));
    w = good_ack();
    w.ack_word = 16'hBAAB;
    plan(w);
  endfunction

  // fill past capacity, then an oversized count that must clamp to the buffer size
  function automatic void plan_full_buffer();
    repeat (MAX_B + 6) plan(load_word(8'($urandom)));
    plan(start_word(11'h7FF, W16'($urandom), 11'd2047));
    repeat (9) plan(good_ack());
    plan(rand_word(REQ_REFUSE));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // ---------------- input driver ----------------

  always @(posedge clk) begin : driver
    logic took;
    sfs_out_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (in_valid && in_stall) held_cycles++;
      if (took) begin
        words_sent++;
        if (sender_step(CHK, in_data, r) == EFF_RESULT) due_results.push_back(r);
      end
      if (in_valid && !took) begin
        // stalled word stays put
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tx_backlog.size() != 0) begin
        in_data <= tx_backlog.pop_front();
        in_valid <= 1'b1;
        if (send_calm != 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 59) == 0) begin
          send_calm = $urandom_range(20, 60);
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk) begin : monitor
    sfs_out_t want;
    logic go_long;
    go_long = 1'b0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.frame_data, '0);
        end else begin
          want = due_results.pop_front();
          if (out_data.result_kind !== want.result_kind)
            report_mismatch("result_kind", out_data.result_kind, want.result_kind);
          if (out_data.frame_id !== want.frame_id)
            report_mismatch("frame_id", out_data.frame_id, want.frame_id);
          if (out_data.frame_data !== want.frame_data)
            report_mismatch("frame_data", out_data.frame_data, want.frame_data);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
        if (out_data.result_kind == RK_DONE) dones_seen++;
        else frames_seen++;
        results_seen++;
        // long hold-off so the input side backs up
        go_long = (results_seen == 12 || results_seen == 45);
      end
      if (go_long) begin
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_calm != 0) begin
        recv_calm--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        recv_calm = $urandom_range(30, 120);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
        hold_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- register port ----------------

  task cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tmo[CHK] = val[15:0];
    tmo[PLAN] = val[15:0];
  endtask

  task cfg_check(input logic [CFG_AW-1:0] addr, input logic [15:0] want);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== want) report_mismatch("timeout readback", cfg_prdata, want);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task settle();
    while (tx_backlog.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  // ---------------- sequencing ----------------

  initial begin : main
    int unsigned tmo_plan [NUM_SETTINGS];
    int unsigned item_plan [NUM_SETTINGS];
    tmo_plan = '{100, 65535, 1, 0, 3, 20};
    item_plan = '{20, 8, 20, 15, 20, 20};
    sender_reset(CHK);
    sender_reset(PLAN);
    tmo_plan[NUM_SETTINGS-1] = $urandom_range(4, 40);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check(TIMEOUT_ADDR, TIMEOUT_RST);
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p == 0) begin
        plan_directed();
      end else begin
        settle();
        cfg_write(TIMEOUT_ADDR, CFG_DW'(tmo_plan[p]));
        cfg_check(TIMEOUT_ADDR, 16'(tmo_plan[p]));
      end
      if (p == 1) plan_full_buffer();
      plan_random(item_plan[p]);
    end
    settle();
    if (due_results.size() != 0)
      report_mismatch("results never delivered", due_results.size(), 0);
    $display("tb: %0d words accepted, %0d frames and %0d completions checked",
             words_sent, frames_seen, dones_seen);
    $display("tb: input held off for %0d cycles; timeouts of 0, 1, 3, 100, 65535 and %0d",
             held_cycles, tmo_plan[NUM_SETTINGS-1]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sfs_pkg.sv
src/sfs_ram.sv
src/sfs_front.sv
src/sfs_back.sv
src/segmented_frame_sender_acked.sv
test/tb_top.sv
